// File: sv/grayscale_bitplane_slicer_top_macros.svh
// assertion macros for the grayscale bit-plane slicer
// no dependencies; included by modules that carry concurrent checks
`ifndef GRAYSCALE_BITPLANE_SLICER_TOP_MACROS_SVH
`define GRAYSCALE_BITPLANE_SLICER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbs assertion failed");
`define GBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbs assertion failed");
`else
`define GBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/gbs_pkg.sv
// shared constants, types and tables of the grayscale bit-plane slicer
// no dependencies
package gbs_pkg;

  localparam int MAX_PLANES  = 8;
  localparam int MAX_BYTES   = 4096;
  localparam int PLANE_W     = 3;
  localparam int BYTE_IDX_W  = 12;
  localparam int LIMIT_W     = 13;
  localparam int NPLANES_W   = 4;
  localparam int PIXEL_W     = 8;
  localparam int THR_W       = 12;

  localparam logic [PIXEL_W-1:0] MASK_MSB = 8'h80;

  // configuration register indexes
  localparam logic REG_NUM_PLANES  = 1'b0;
  localparam logic REG_IMAGE_BYTES = 1'b1;

  typedef logic [MAX_PLANES-1:0][PIXEL_W-1:0] plane_bytes_t;

  // one packed byte per plane, handed over on the eighth pixel of a group
  typedef struct packed {
    logic                  load;
    plane_bytes_t          bytes;
    logic [PLANE_W-1:0]    last_plane;
    logic [BYTE_IDX_W-1:0] byte_index;
  } burst_t;

  // threshold step 255 / planes, indexed by planes - 1
  localparam logic [PIXEL_W-1:0] STEP_TABLE [MAX_PLANES] = '{
    8'd255, 8'd127, 8'd85, 8'd63, 8'd51, 8'd42, 8'd36, 8'd31
  };

endpackage

// File: sv/gbs_slicer.sv
// thresholds each pixel against the plane levels and packs the bits
// depends on gbs_pkg
module gbs_slicer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [gbs_pkg::NPLANES_W-1:0]     num_planes,
  input  logic [gbs_pkg::LIMIT_W-1:0]       image_bytes,
  input  logic                              pix_take,
  input  logic [gbs_pkg::PIXEL_W-1:0]       pixel,
  output logic                              group_end,
  output gbs_pkg::burst_t                   burst
);

  logic [2:0]                        bitpos_r;
  logic [gbs_pkg::BYTE_IDX_W-1:0]    bcount_r;
  gbs_pkg::plane_bytes_t             acc_r;
  gbs_pkg::plane_bytes_t             acc_nxt;
  logic [gbs_pkg::PLANE_W-1:0]       last_plane;
  logic [gbs_pkg::PIXEL_W-1:0]       step;
  logic [gbs_pkg::PIXEL_W-1:0]       mask;
  logic [gbs_pkg::LIMIT_W-1:0]       limit;
  logic                              wrap;

  always_comb begin
    if (num_planes == '0) begin
      last_plane = '0;
    end else if (num_planes > gbs_pkg::NPLANES_W'(gbs_pkg::MAX_PLANES)) begin
      last_plane = gbs_pkg::PLANE_W'(gbs_pkg::MAX_PLANES - 1);
    end else begin
      last_plane = gbs_pkg::PLANE_W'(num_planes - 4'd1);
    end
    step = gbs_pkg::STEP_TABLE[last_plane];
    mask = gbs_pkg::MASK_MSB >> bitpos_r;
  end

  // plane j takes a 1 when the pixel is at or below (j+1)*step
  always_comb begin
    logic [gbs_pkg::THR_W-1:0] thr;
    for (int j = 0; j < gbs_pkg::MAX_PLANES; j++) begin
      thr = gbs_pkg::THR_W'(j + 1) * gbs_pkg::THR_W'(step);
      if ((gbs_pkg::THR_W'(pixel) <= thr) &&
          (gbs_pkg::PLANE_W'(j) <= last_plane)) begin
        acc_nxt[j] = acc_r[j] | mask;
      end else begin
        acc_nxt[j] = acc_r[j];
      end
    end
  end

  always_comb begin
    if ((image_bytes == '0) ||
        (image_bytes > gbs_pkg::LIMIT_W'(gbs_pkg::MAX_BYTES))) begin
      limit = gbs_pkg::LIMIT_W'(gbs_pkg::MAX_BYTES);
    end else begin
      limit = image_bytes;
    end
    wrap = ({1'b0, bcount_r} + 13'd1) >= limit;
  end

  assign group_end        = (bitpos_r == 3'd7);
  assign burst.load       = pix_take && group_end;
  assign burst.bytes      = acc_nxt;
  assign burst.last_plane = last_plane;
  assign burst.byte_index = bcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitpos_r <= '0;
      bcount_r <= '0;
      acc_r    <= '0;
    end else if (pix_take) begin
      if (group_end) begin
        bitpos_r <= '0;
        acc_r    <= '0;
        bcount_r <= wrap ? '0 : bcount_r + 12'd1;
      end else begin
        bitpos_r <= bitpos_r + 3'd1;
        acc_r    <= acc_nxt;
      end
    end
  end

endmodule

// File: sv/gbs_burst.sv
// output register that sends one packed byte per active plane, one per cycle while out_stall is low
// depends on gbs_pkg and the assertion macro header
`include "grayscale_bitplane_slicer_top_macros.svh"
module gbs_burst (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gbs_pkg::burst_t                   burst,
  output logic                              free,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gbs_pkg::PLANE_W-1:0]       out_plane_index,
  output logic [gbs_pkg::BYTE_IDX_W-1:0]    out_byte_index,
  output logic [gbs_pkg::PIXEL_W-1:0]       out_plane_byte,
  output logic                              out_last_of_burst
);

  logic                              busy_r;
  logic [gbs_pkg::PLANE_W-1:0]       ptr_r;
  logic [gbs_pkg::PLANE_W-1:0]       last_r;
  logic [gbs_pkg::BYTE_IDX_W-1:0]    idx_r;
  gbs_pkg::plane_bytes_t             bytes_r;
  gbs_pkg::plane_bytes_t             bytes_nxt;
  logic                              take;
  logic                              at_last;

  assign take    = busy_r && !out_stall;
  assign at_last = (ptr_r == last_r);
  // a new burst may load in the cycle the final byte leaves
  assign free    = !busy_r || (!out_stall && at_last);

  always_comb begin
    for (int i = 0; i < gbs_pkg::MAX_PLANES - 1; i++) begin
      bytes_nxt[i] = bytes_r[i+1];
    end
    bytes_nxt[gbs_pkg::MAX_PLANES-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ptr_r  <= '0;
      last_r <= '0;
    end else if (burst.load) begin
      busy_r <= 1'b1;
      ptr_r  <= '0;
      last_r <= burst.last_plane;
    end else if (take) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        ptr_r <= ptr_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      bytes_r <= burst.bytes;
      idx_r   <= burst.byte_index;
    end else if (take && !at_last) begin
      bytes_r <= bytes_nxt;
    end
  end

  assign out_valid         = busy_r;
  assign out_plane_index   = ptr_r;
  assign out_byte_index    = idx_r;
  assign out_plane_byte    = bytes_r[0];
  assign out_last_of_burst = at_last;

  `GBS_ASSERT_IMP(a_load_when_free, clk, rst_n, burst.load, free)
  `GBS_ASSERT_IMP(a_ptr_in_range, clk, rst_n, busy_r, ptr_r <= last_r)
  `GBS_ASSERT_NXT(a_drain_ends, clk, rst_n, take && at_last && !burst.load, !busy_r)
  `GBS_ASSERT_NXT(a_hold_stalled, clk, rst_n, busy_r && out_stall && !burst.load,
                  busy_r && $stable(ptr_r))

endmodule

// File: sv/grayscale_bitplane_slicer_top.sv
// top level of the grayscale bit-plane slicer: config registers and handshake
// depends on gbs_pkg, gbs_slicer and gbs_burst
//
// Takes one 8-bit pixel per cycle while in_stall is low and slices it into
// 1..8 bit planes against thresholds j*floor(255/planes). Every eighth pixel
// loads one packed byte per active plane into the output register, which sends
// them one per cycle while out_stall is low, plane 0 first, with last_of_burst
// on the final plane. The eighth pixel of a group is held off only while the
// previous burst still has bytes waiting beyond the one leaving this cycle, so
// with the output side not stalled the block sustains one pixel per cycle at
// any plane count. Write configuration only while idle.
module grayscale_bitplane_slicer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [gbs_pkg::LIMIT_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gbs_pkg::PIXEL_W-1:0]       in_pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gbs_pkg::PLANE_W-1:0]       out_plane_index,
  output logic [gbs_pkg::BYTE_IDX_W-1:0]    out_byte_index,
  output logic [gbs_pkg::PIXEL_W-1:0]       out_plane_byte,
  output logic                              out_last_of_burst
);

  logic [gbs_pkg::NPLANES_W-1:0]   num_planes_r;
  logic [gbs_pkg::LIMIT_W-1:0]     image_bytes_r;
  logic                            group_end;
  logic                            free;
  logic                            pix_take;
  gbs_pkg::burst_t                 burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_planes_r  <= 4'd6;
      image_bytes_r <= 13'd3840;
    end else if (cfg_we) begin
      case (cfg_index)
        gbs_pkg::REG_NUM_PLANES: begin
          num_planes_r <= cfg_wdata[gbs_pkg::NPLANES_W-1:0];
        end
        gbs_pkg::REG_IMAGE_BYTES: begin
          image_bytes_r <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall = group_end && !free;
  assign pix_take = in_valid && !in_stall;

  gbs_slicer u_slicer (
    .clk         (clk),
    .rst_n       (rst_n),
    .num_planes  (num_planes_r),
    .image_bytes (image_bytes_r),
    .pix_take    (pix_take),
    .pixel       (in_pixel),
    .group_end   (group_end),
    .burst       (burst)
  );

  gbs_burst u_burst (
    .clk               (clk),
    .rst_n             (rst_n),
    .burst             (burst),
    .free              (free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_plane_index   (out_plane_index),
    .out_byte_index    (out_byte_index),
    .out_plane_byte    (out_plane_byte),
    .out_last_of_burst (out_last_of_burst)
  );

endmodule

// File: bench/tb_grayscale_bitplane_slicer_top.sv
// self-checking bench for grayscale_bitplane_slicer_top: directed and random pixel traffic
// predicts every packed plane byte and checks each result in order
// depends on gbs_pkg and grayscale_bitplane_slicer_top
module tb_grayscale_bitplane_slicer_top;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 13;

  typedef struct packed {
    logic [gbs_pkg::PLANE_W-1:0]    plane;
    logic [gbs_pkg::BYTE_IDX_W-1:0] offset;
    logic [gbs_pkg::PIXEL_W-1:0]    bits;
    logic                           last;
  } sliced_byte_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic                           cfg_index;
  logic [gbs_pkg::LIMIT_W-1:0]    cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [gbs_pkg::PIXEL_W-1:0]    in_pixel;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [gbs_pkg::PLANE_W-1:0]    out_plane_index;
  logic [gbs_pkg::BYTE_IDX_W-1:0] out_byte_index;
  logic [gbs_pkg::PIXEL_W-1:0]    out_plane_byte;
  logic                           out_last_of_burst;

  // local copy of the block's registers and packing state
  logic [gbs_pkg::NPLANES_W-1:0]  planes_reg;
  logic [gbs_pkg::LIMIT_W-1:0]    image_reg;
  logic [2:0]                     slot;
  logic [gbs_pkg::BYTE_IDX_W-1:0] byte_offset;
  logic [gbs_pkg::PIXEL_W-1:0]    plane_acc [gbs_pkg::MAX_PLANES];

  sliced_byte_t packed_bytes_due [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  grayscale_bitplane_slicer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_plane_index   (out_plane_index),
    .out_byte_index    (out_byte_index),
    .out_plane_byte    (out_plane_byte),
    .out_last_of_burst (out_last_of_burst)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_planes();
    if (planes_reg == 0) return 1;
    if (planes_reg > gbs_pkg::MAX_PLANES) return gbs_pkg::MAX_PLANES;
    return int'(planes_reg);
  endfunction

  // slice one accepted pixel; on the eighth pixel queue one byte per active plane
  function automatic void slice_pixel(logic [gbs_pkg::PIXEL_W-1:0] px);
    int planes;
    int step;
    int limit;
    logic [gbs_pkg::PIXEL_W-1:0] mask;
    sliced_byte_t sb;
    planes = active_planes();
    step = 255 / planes;
    mask = gbs_pkg::MASK_MSB >> slot;
    for (int j = 0; j < planes; j++) begin
      if (int'(px) <= (j + 1) * step) plane_acc[j] = plane_acc[j] | mask;
    end
    if (slot != 3'd7) begin
      slot = slot + 3'd1;
      return;
    end
    for (int j = 0; j < planes; j++) begin
      sb.plane = gbs_pkg::PLANE_W'(j);
      sb.offset = byte_offset;
      sb.bits = plane_acc[j];
      sb.last = (j + 1 == planes);
      packed_bytes_due.push_back(sb);
    end
    for (int j = 0; j < gbs_pkg::MAX_PLANES; j++) plane_acc[j] = '0;
    slot = 3'd0;
    limit = (image_reg == 0 || image_reg > gbs_pkg::MAX_BYTES) ?
            gbs_pkg::MAX_BYTES : int'(image_reg);
    if (int'(byte_offset) + 1 >= limit) byte_offset = '0;
    else byte_offset = byte_offset + 1'b1;
  endfunction

  // mostly uniform, with a good share at or just above a plane threshold and at the rails
  function automatic logic [gbs_pkg::PIXEL_W-1:0] pick_pixel();
    int planes;
    int t;
    planes = active_planes();
    case ($urandom_range(3))
      0: begin
        t = $urandom_range(1, planes) * (255 / planes) + $urandom_range(0, 1);
        if (t > 255) t = 255;
        return gbs_pkg::PIXEL_W'(t);
      end
      1: return $urandom_range(1) ? 8'hff : 8'h00;
      default: return gbs_pkg::PIXEL_W'($urandom_range(255));
    endcase
  endfunction

  // offer one pixel request and hold it until accepted
  task automatic send_pixel(logic [gbs_pkg::PIXEL_W-1:0] px);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_pixel = gbs_pkg::PIXEL_W'($urandom_range(255));
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_pixel = px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slice_pixel(px);
  endtask

  // register writes only once every queued byte has come out and the block settled
  task automatic write_reg(logic idx, logic [gbs_pkg::LIMIT_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (packed_bytes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    if (idx == gbs_pkg::REG_NUM_PLANES) planes_reg = value[gbs_pkg::NPLANES_W-1:0];
    else image_reg = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = '0;
  endtask

  task automatic test_directed_thresholds();
    logic [gbs_pkg::PIXEL_W-1:0] at_reset [16] = '{
      8'd0, 8'd42, 8'd43, 8'd84, 8'd85, 8'd252, 8'd253, 8'd255,
      8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128
    };
    logic [gbs_pkg::PIXEL_W-1:0] clamped [8] = '{
      8'd31, 8'd32, 8'd248, 8'd249, 8'd0, 8'd255, 8'd124, 8'd125
    };
    idle_pct = 0;
    stall_pct = 0;
    // reset settings: six planes, step 42
    foreach (at_reset[i]) send_pixel(at_reset[i]);
    // plane count above the maximum clamps to eight, step 31
    write_reg(gbs_pkg::REG_NUM_PLANES, 13'd15);
    foreach (clamped[i]) send_pixel(clamped[i]);
  endtask

  task automatic test_shrinking_image();
    idle_pct = 0;
    stall_pct = 30;
    write_reg(gbs_pkg::REG_NUM_PLANES, 13'd8);
    repeat (16) send_pixel(pick_pixel());
    // counter is past the new limit, so it restarts after the next byte
    write_reg(gbs_pkg::REG_IMAGE_BYTES, 13'd2);
    repeat (32) send_pixel(pick_pixel());
  endtask

  task automatic test_random_traffic();
    int idle_set [4] = '{0, 81, 0, 32};
    int stall_set [4] = '{0, 0, 81, 32};
    logic [gbs_pkg::LIMIT_W-1:0] planes_set [4] = '{13'd0, 13'd1, 13'd8, 13'd0};
    logic [gbs_pkg::LIMIT_W-1:0] image_set [4] = '{13'd1, 13'd8191, 13'd4096, 13'd0};
    for (int p = 0; p < 4; p++) begin
      write_reg(gbs_pkg::REG_NUM_PLANES, planes_set[p] == 0 && p == 3 ?
                gbs_pkg::LIMIT_W'($urandom_range(15)) : planes_set[p]);
      write_reg(gbs_pkg::REG_IMAGE_BYTES, image_set[p] == 0 && p == 3 ?
                gbs_pkg::LIMIT_W'($urandom_range(1, 16)) : image_set[p]);
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      // item count is not a multiple of eight, so the next write lands mid-byte
      repeat (RANDOM_ITEMS) send_pixel(pick_pixel());
      // plane count change with a partly packed byte
      write_reg(gbs_pkg::REG_NUM_PLANES, gbs_pkg::LIMIT_W'($urandom_range(15)));
      repeat (11) send_pixel(pick_pixel());
    end
  endtask

  task automatic test_zero_image_size();
    idle_pct = 0;
    stall_pct = 0;
    // zero image size means the full 4096 bytes, so offsets keep counting up
    write_reg(gbs_pkg::REG_NUM_PLANES, 13'd1);
    write_reg(gbs_pkg::REG_IMAGE_BYTES, 13'd0);
    repeat (16) send_pixel(gbs_pkg::PIXEL_W'($urandom_range(255)));
  endtask

  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    sliced_byte_t sb;
    if (rst_n && out_valid && !out_stall) begin
      if (packed_bytes_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count < 100)
          $error("unexpected plane byte: plane %0d byte %0d data %h",
                 out_plane_index, out_byte_index, out_plane_byte);
      end else begin
        sb = packed_bytes_due.pop_front();
        if (out_plane_index !== sb.plane) begin
          mismatch_count++;
          if (mismatch_count < 100)
            $error("plane_index: expected %0d, got %0d", sb.plane, out_plane_index);
        end
        if (out_byte_index !== sb.offset) begin
          mismatch_count++;
          if (mismatch_count < 100)
            $error("byte_index: expected %0d, got %0d", sb.offset, out_byte_index);
        end
        if (out_plane_byte !== sb.bits) begin
          mismatch_count++;
          if (mismatch_count < 100)
            $error("plane_byte: expected %h, got %h", sb.bits, out_plane_byte);
        end
        if (out_last_of_burst !== sb.last) begin
          mismatch_count++;
          if (mismatch_count < 100)
            $error("last_of_burst: expected %b, got %b", sb.last, out_last_of_burst);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = gbs_pkg::REG_NUM_PLANES;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_pixel = '0;
    planes_reg = gbs_pkg::NPLANES_W'(6);
    image_reg = gbs_pkg::LIMIT_W'(3840);
    slot = '0;
    byte_offset = '0;
    for (int j = 0; j < gbs_pkg::MAX_PLANES; j++) plane_acc[j] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_thresholds();
    test_shrinking_image();
    test_random_traffic();
    test_zero_image_size();

    @(negedge clk);
    in_valid = 1'b0;
    while (packed_bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && packed_bytes_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
